>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> rtl/rbpd_pkg.sv
// ----------------------------------------------------------------------------
// rbpd_pkg
// shared types and constants of the receive byte ring with peek and drop
// ----------------------------------------------------------------------------
package rbpd_pkg;

    // default geometry
    localparam int RING_SLOTS = 256;
    localparam int MAX_BURST  = 64;

    // stream widths
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;

    // request kinds carried on tuser
    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_PEEK  = 2'd1,
        REQ_DROP  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    // controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_PEEK = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_req;   // input beat accepted this cycle
        logic peek_emit;  // load the read byte into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a beat
        logic peek_start; // pending request is a peek that returns bytes
        logic peek_last;  // one peeked byte left
    } t_status;

endpackage

>>> rtl/rbpd_ram.sv
// ----------------------------------------------------------------------------
// rbpd_ram
// generic single write, single read RAM with registered read data
// ----------------------------------------------------------------------------
module rbpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rbpd_datapath.sv
// ----------------------------------------------------------------------------
// rbpd_datapath
// ring indices, overflow flag, byte store, peek address walk, output register
// ----------------------------------------------------------------------------
module rbpd_datapath #(
    parameter int RING_SLOTS = rbpd_pkg::RING_SLOTS,
    parameter int MAX_BURST  = rbpd_pkg::MAX_BURST
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rbpd_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [rbpd_pkg::S_USER_W-1:0] i_s_tuser,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [rbpd_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast,
    input  rbpd_pkg::t_cmd                i_cmd,
    output rbpd_pkg::t_status             o_status
);

    localparam int IW = $clog2(RING_SLOTS);
    localparam int CW = ((IW > 9) ? IW : 9) + 1;
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam int FW = (IW > 8) ? IW : 8;
    localparam logic [CW-1:0] SLOTS_C = CW'(RING_SLOTS);
    localparam logic [CW-1:0] BURST_C = CW'(MAX_BURST);
    localparam logic [IW:0]   SLOTS_X = (IW + 1)'(RING_SLOTS);
    localparam logic [IW-1:0] LAST_IX = IW'(RING_SLOTS - 1);

    // request fields
    rbpd_pkg::t_req req;
    logic [7:0]     rx_byte;
    logic [7:0]     offset;
    logic [7:0]     count;

    // architectural state
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_wr_idx, n_wr_idx;
    logic          r_ovf, n_ovf;

    // peek walk
    logic [IW-1:0] r_paddr, n_paddr;
    logic [BW-1:0] r_remain, n_remain;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_ok, n_out_ok;
    logic          r_out_last, n_out_last;
    logic [7:0]    r_out_fill, n_out_fill;
    logic          r_out_ovf, n_out_ovf;

    // decode helpers
    logic [IW:0]   diff;
    logic [IW-1:0] level;
    logic [IW-1:0] wr_inc;
    logic          full;
    logic [CW-1:0] lvl_c, rd_c, off_c, cnt_c;
    logic          peek_fail;
    logic [CW-1:0] start_sum, drop_sum;
    logic [IW-1:0] start_addr, drop_idx;
    logic          drop_fail;
    logic [IW-1:0] paddr_inc;
    logic          single_ok;
    logic [IW-1:0] fill_after;
    logic [FW-1:0] fill_w;
    logic [FW-1:0] level_w;
    logic          we;
    logic          re;
    logic [IW-1:0] raddr;
    logic [7:0]    rdata;

    assign req     = rbpd_pkg::t_req'(i_s_tuser);
    assign rx_byte = i_s_tdata[7:0];
    assign offset  = i_s_tdata[15:8];
    assign count   = i_s_tdata[23:16];

    // fill level, wrap at the true slot count
    always_comb begin
        diff = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
        if (r_wr_idx < r_rd_idx) begin
            diff = diff + SLOTS_X;
        end
        level = diff[IW-1:0];
    end

    assign wr_inc = (r_wr_idx == LAST_IX) ? '0 : r_wr_idx + IW'(1);
    assign full   = (wr_inc == r_rd_idx);

    // range checks and wrapped positions
    assign lvl_c     = CW'(level);
    assign rd_c      = CW'(r_rd_idx);
    assign off_c     = CW'(offset);
    assign cnt_c     = CW'(count);
    assign peek_fail = (cnt_c > BURST_C) || (off_c + cnt_c > lvl_c);
    assign drop_fail = (cnt_c > lvl_c);
    assign start_sum = rd_c + off_c;
    assign drop_sum  = rd_c + cnt_c;

    always_comb begin
        if (start_sum >= SLOTS_C) begin
            start_addr = IW'(start_sum - SLOTS_C);
        end else begin
            start_addr = IW'(start_sum);
        end
        if (drop_sum >= SLOTS_C) begin
            drop_idx = IW'(drop_sum - SLOTS_C);
        end else begin
            drop_idx = IW'(drop_sum);
        end
    end

    assign paddr_inc = (r_paddr == LAST_IX) ? '0 : r_paddr + IW'(1);

    // single result requests, next index values
    always_comb begin
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_ovf     = r_ovf;
        single_ok = 1'b1;
        we        = 1'b0;
        case (req)
            rbpd_pkg::REQ_PUSH: begin
                if (full) begin
                    n_ovf     = 1'b1;
                    single_ok = 1'b0;
                end else begin
                    n_wr_idx = wr_inc;
                    we       = i_cmd.take_req;
                end
            end
            rbpd_pkg::REQ_PEEK: begin
                single_ok = !peek_fail;
            end
            rbpd_pkg::REQ_DROP: begin
                if (drop_fail) begin
                    single_ok = 1'b0;
                end else begin
                    n_rd_idx = drop_idx;
                end
            end
            rbpd_pkg::REQ_CLEAR: begin
                n_rd_idx = r_wr_idx;
            end
            default: begin
                single_ok = 1'b0;
            end
        endcase
    end

    // fill level after a single result request
    always_comb begin
        diff_after_blk: begin
            logic [IW:0] d;
            d = {1'b0, n_wr_idx} - {1'b0, n_rd_idx};
            if (n_wr_idx < n_rd_idx) begin
                d = d + SLOTS_X;
            end
            fill_after = d[IW-1:0];
        end
    end

    assign fill_w  = FW'(fill_after);
    assign level_w = FW'(level);

    // status to the controller
    assign o_status.out_free   = !r_out_valid || i_m_tready;
    assign o_status.peek_start = (req == rbpd_pkg::REQ_PEEK) && !peek_fail && (count != 8'd0);
    assign o_status.peek_last  = (r_remain == BW'(1));

    // byte store reads: first byte on peek start, next byte on each emit but the last
    always_comb begin
        re    = 1'b0;
        raddr = r_paddr;
        if (i_cmd.take_req && o_status.peek_start) begin
            re    = 1'b1;
            raddr = start_addr;
        end else if (i_cmd.peek_emit && !o_status.peek_last) begin
            re    = 1'b1;
            raddr = paddr_inc;
        end
    end

    // peek walk update
    always_comb begin
        n_paddr  = r_paddr;
        n_remain = r_remain;
        if (i_cmd.take_req && o_status.peek_start) begin
            n_paddr  = start_addr;
            n_remain = count[BW-1:0];
        end else if (i_cmd.peek_emit) begin
            n_paddr  = paddr_inc;
            n_remain = r_remain - BW'(1);
        end
    end

    // output register load
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_ok    = r_out_ok;
        n_out_last  = r_out_last;
        n_out_fill  = r_out_fill;
        n_out_ovf   = r_out_ovf;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.take_req && !o_status.peek_start) begin
            n_out_valid = 1'b1;
            n_out_byte  = 8'd0;
            n_out_ok    = single_ok;
            n_out_last  = 1'b1;
            n_out_fill  = fill_w[7:0];
            n_out_ovf   = n_ovf;
        end else if (i_cmd.peek_emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = rdata;
            n_out_ok    = 1'b1;
            n_out_last  = o_status.peek_last;
            n_out_fill  = level_w[7:0];
            n_out_ovf   = r_ovf;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_remain    <= '0;
        end else begin
            if (i_cmd.take_req) begin
                r_rd_idx <= n_rd_idx;
                r_wr_idx <= n_wr_idx;
                r_ovf    <= n_ovf;
            end
            r_out_valid <= n_out_valid;
            r_remain    <= n_remain;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_paddr    <= n_paddr;
        r_out_byte <= n_out_byte;
        r_out_ok   <= n_out_ok;
        r_out_last <= n_out_last;
        r_out_fill <= n_out_fill;
        r_out_ovf  <= n_out_ovf;
    end

    // byte store
    rbpd_ram #(
        .WIDTH (8),
        .DEPTH (RING_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_idx),
        .i_wdata (rx_byte),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result beat
    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'd0, r_out_ovf, r_out_fill, r_out_ok, r_out_byte};

endmodule

>>> rtl/rbpd_ctrl.sv
// ----------------------------------------------------------------------------
// rbpd_ctrl
// request sequencer: takes requests and walks peek bursts
// ----------------------------------------------------------------------------
module rbpd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  rbpd_pkg::t_status    i_status,
    output rbpd_pkg::t_cmd       o_cmd
);

    rbpd_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbpd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rbpd_pkg::ST_IDLE: begin
                if (i_s_tvalid && i_status.out_free && i_status.peek_start) begin
                    n_state = rbpd_pkg::ST_PEEK;
                end
            end
            rbpd_pkg::ST_PEEK: begin
                if (i_status.out_free && i_status.peek_last) begin
                    n_state = rbpd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbpd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd.take_req  = 1'b0;
        o_cmd.peek_emit = 1'b0;
        case (r_state)
            rbpd_pkg::ST_IDLE: begin
                o_s_tready     = i_status.out_free;
                o_cmd.take_req = i_s_tvalid && i_status.out_free;
            end
            rbpd_pkg::ST_PEEK: begin
                o_cmd.peek_emit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/rx_byte_ring_peek_drop.sv
// Push, drop, clear and refused requests: one beat taken per cycle while out_free is set.
// Peek of n bytes: first byte via the store read data and output registers, then one byte per
// cycle while out_free is set, paced by the single registered read port of the byte store.
// Output register lets a request be taken while the previous result is being drained.
// Synchronous active-low reset empties the ring and clears overflow; stored bytes are kept.
// ----------------------------------------------------------------------------
// rx_byte_ring_peek_drop
// receive byte ring with push, peek, drop and clear requests
// ----------------------------------------------------------------------------
module rx_byte_ring_peek_drop #(
    parameter int RING_SLOTS = rbpd_pkg::RING_SLOTS,
    parameter int MAX_BURST  = rbpd_pkg::MAX_BURST
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request beat
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rbpd_pkg::S_DATA_W-1:0] i_s_tdata,  // rx_byte, offset, count
    input  logic [rbpd_pkg::S_USER_W-1:0] i_s_tuser,  // req_type
    // result beat
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rbpd_pkg::M_DATA_W-1:0] o_m_tdata,  // read_byte, ok, fill_level, overflow, pad
    output logic                          o_m_tlast
);

    rbpd_pkg::t_cmd    cmd;
    rbpd_pkg::t_status status;

    // sequencer
    rbpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // ring datapath
    rbpd_datapath #(
        .RING_SLOTS (RING_SLOTS),
        .MAX_BURST  (MAX_BURST)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

>>> rtl/rbpd_checker.sv
// ----------------------------------------------------------------------------
// rbpd_checker
// port level checks of the receive byte ring, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbpd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [rbpd_pkg::M_DATA_W-1:0] o_m_tdata,
    input logic                          o_m_tlast
);

    // stalled result beat holds
    `ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "result beat changed while stalled")

    // a refused request gives one beat with no data byte
    `ASSERT_CLK(a_refused_single, o_m_tvalid && !o_m_tdata[8] |-> o_m_tlast && o_m_tdata[7:0] == 8'd0, "refused result is not a single empty beat")

    // no new request while a peek burst is still running
    `ASSERT_CLK(a_burst_blocks, o_m_tvalid && !o_m_tlast |-> !o_s_tready, "request taken during a peek burst")

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind rx_byte_ring_peek_drop rbpd_checker u_rbpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
